### hdl/column_l2_normalizer_core_assert.svh
// Assertion macros shared by the column L2 normalizer RTL.
`ifndef COLUMN_L2_NORMALIZER_CORE_ASSERT_SVH
`define COLUMN_L2_NORMALIZER_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// Plain property check on the rising edge, disabled while reset is asserted.
`define CL2N_ASSERT(lbl, clk_sig, rst_n_sig, prop) \
	lbl: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) (prop)) \
		else $error("column_l2_normalizer_core: assertion failed");
// Overlapping implication built on the macro above.
`define CL2N_ASSERT_IMPLY(lbl, clk_sig, rst_n_sig, ante, cons) \
	`CL2N_ASSERT(lbl, clk_sig, rst_n_sig, (ante) |-> (cons))
`else
`define CL2N_ASSERT(lbl, clk_sig, rst_n_sig, prop)
`define CL2N_ASSERT_IMPLY(lbl, clk_sig, rst_n_sig, ante, cons)
`endif

`endif

### hdl/cl2n_pkg.sv
// Types and constants shared by the column L2 normalizer modules.
`timescale 1ns / 1ps

package cl2n_pkg;

	localparam int COLUMNS   = 4;
	localparam int COL_W     = 2;
	localparam int MODE_W    = 2;
	localparam int SAMPLE_W  = 16;
	localparam int SQUARE_W  = 2 * SAMPLE_W;
	localparam int SUM_W     = 40;
	localparam int ROOT_W    = SUM_W / 2;
	localparam int RESULT_W  = 16;

	localparam logic [SUM_W-1:0]    SUM_MAX    = {SUM_W{1'b1}};
	localparam logic [RESULT_W-1:0] RESULT_MAX = {RESULT_W{1'b1}};

	typedef enum logic [MODE_W-1:0] {
		MODE_CLEAR = 2'd0,
		MODE_ACCUM = 2'd1,
		MODE_NORM  = 2'd2
	} mode_t;

	typedef enum logic [2:0] {
		CORE_IDLE,
		CORE_SQUARE,
		CORE_ADD,
		CORE_NORM,
		CORE_OUT
	} core_state_t;

	typedef enum logic [2:0] {
		UNIT_IDLE,
		UNIT_ROOT,
		UNIT_PREP,
		UNIT_DIV,
		UNIT_DONE
	} unit_state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} unit_stat_t;

endpackage

### hdl/cl2n_root_div.sv
// Serial square root of a column sum followed by a serial division of the sample by the root.
`timescale 1ns / 1ps
`include "column_l2_normalizer_core_assert.svh"

module cl2n_root_div import cl2n_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [SUM_W-1:0]    sum,
	input  logic [SAMPLE_W-1:0] sample,
	output unit_stat_t          stat,
	output logic [RESULT_W-1:0] quotient,
	output logic                zero
);

	localparam int ROOT_STEPS = ROOT_W;
	localparam int DIV_STEPS  = RESULT_W;
	localparam int CNT_W      = $clog2(ROOT_STEPS);
	localparam int REM_W      = ROOT_W + 1;

	unit_state_t state_q, state_d;

	logic [SUM_W-1:0]    rad_q;
	logic [REM_W-1:0]    rem_q;
	logic [ROOT_W-1:0]   root_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [SAMPLE_W-1:0] sample_q;
	logic [RESULT_W-1:0] quo_q;
	logic                zero_q;

	// One root bit per cycle: bring down two radicand bits, try (root << 2) | 1.
	logic [REM_W+1:0] r_ext;
	logic [REM_W+1:0] r_trial;
	logic             r_fit;
	// One quotient bit per cycle: restoring step against the root.
	logic [REM_W-1:0] d_ext;
	logic [REM_W-1:0] d_div;
	logic             d_fit;

	assign r_ext   = {rem_q, rad_q[SUM_W-1 -: 2]};
	assign r_trial = {1'b0, root_q, 2'b01};
	assign r_fit   = (r_ext >= r_trial);
	assign d_ext   = {rem_q[REM_W-2:0], 1'b0};
	assign d_div   = {1'b0, root_q};
	assign d_fit   = (d_ext >= d_div);

	always_comb begin
		state_d = state_q;
		case (state_q)
			UNIT_IDLE: begin
				if (start) begin
					state_d = UNIT_ROOT;
				end
			end
			UNIT_ROOT: begin
				if (cnt_q == CNT_W'(ROOT_STEPS - 1)) begin
					state_d = UNIT_PREP;
				end
			end
			UNIT_PREP: begin
				if ((root_q == '0) || ({{(ROOT_W-SAMPLE_W){1'b0}}, sample_q} >= root_q)) begin
					state_d = UNIT_DONE;
				end else begin
					state_d = UNIT_DIV;
				end
			end
			UNIT_DIV: begin
				if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
					state_d = UNIT_DONE;
				end
			end
			UNIT_DONE: begin
				state_d = UNIT_IDLE;
			end
			default: begin
				state_d = UNIT_IDLE;
			end
		endcase
	end

	always_comb begin
		stat.busy = (state_q != UNIT_IDLE);
		stat.done = (state_q == UNIT_DONE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= UNIT_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			UNIT_IDLE: begin
				if (start) begin
					rad_q    <= sum;
					rem_q    <= '0;
					root_q   <= '0;
					cnt_q    <= '0;
					sample_q <= sample;
				end
			end
			UNIT_ROOT: begin
				rad_q <= {rad_q[SUM_W-3:0], 2'b00};
				cnt_q <= cnt_q + 1'b1;
				if (r_fit) begin
					rem_q  <= REM_W'(r_ext - r_trial);
					root_q <= {root_q[ROOT_W-2:0], 1'b1};
				end else begin
					rem_q  <= r_ext[REM_W-1:0];
					root_q <= {root_q[ROOT_W-2:0], 1'b0};
				end
			end
			UNIT_PREP: begin
				cnt_q  <= '0;
				rem_q  <= {{(REM_W-SAMPLE_W){1'b0}}, sample_q};
				zero_q <= (root_q == '0);
				if (root_q == '0) begin
					quo_q <= '0;
				end else begin
					quo_q <= RESULT_MAX;
				end
			end
			UNIT_DIV: begin
				cnt_q <= cnt_q + 1'b1;
				if (d_fit) begin
					rem_q <= d_ext - d_div;
					quo_q <= {quo_q[RESULT_W-2:0], 1'b1};
				end else begin
					rem_q <= d_ext;
					quo_q <= {quo_q[RESULT_W-2:0], 1'b0};
				end
			end
			default: begin
			end
		endcase
	end

	assign quotient = quo_q;
	assign zero     = zero_q;

	// The root remainder never exceeds twice the partial root.
	`CL2N_ASSERT_IMPLY(a_root_rem_bound, clk, arst_n, state_q == UNIT_ROOT,
		rem_q <= {root_q, 1'b0})
	// During division the remainder stays below the divisor.
	`CL2N_ASSERT_IMPLY(a_div_rem_bound, clk, arst_n, state_q == UNIT_DIV,
		rem_q < {1'b0, root_q})
	// A zero norm always comes with a zero quotient.
	`CL2N_ASSERT_IMPLY(a_zero_result, clk, arst_n, stat.done && zero_q, quo_q == '0)

endmodule

### hdl/column_l2_normalizer_core.sv
// Top level of the column L2 normalizer: handshake, column sums, serial squarer and result register.
// A clear item is handled in the idle state; an accumulate item runs the serial square, then an add step.
// A normalize item shows its result on m_axis after the root, divide and control steps; the divide
// is skipped when the norm is zero or the result saturates.
// The core takes no new item until the last one is through, so the bit-serial root and divide unit bounds the rate.
// Reset (arst_n low, asynchronous) clears all column sums, overflow marks, control and valid state.
`timescale 1ns / 1ps
`include "column_l2_normalizer_core_assert.svh"

module column_l2_normalizer_core import cl2n_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// Input items.
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,   // [15:0] sample (unsigned Q8.8)
	input  logic [3:0]  s_axis_tuser,   // [1:0] mode, [3:2] column
	// Result items.
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,   // [15:0] normalized (unsigned Q0.16)
	output logic [3:0]  m_axis_tuser    // [1:0] out_column, [2] zero_norm, [3] sum_overflow
);

	localparam int SQ_STEPS = SAMPLE_W;
	localparam int SQ_CNT_W = $clog2(SQ_STEPS);

	// Unpacked input fields.
	logic [MODE_W-1:0]   in_mode;
	logic [COL_W-1:0]    in_col;
	logic [SAMPLE_W-1:0] in_sample;
	logic                in_accept;

	assign in_sample = s_axis_tdata[SAMPLE_W-1:0];
	assign in_mode   = s_axis_tuser[MODE_W-1:0];
	assign in_col    = s_axis_tuser[MODE_W +: COL_W];
	assign in_accept = s_axis_tvalid && s_axis_tready;

	core_state_t state_q, state_d;

	// Per-column state. Each column keeps a 40-bit sum of squares and a sticky overflow mark.
	logic [SUM_W-1:0] sums_q [COLUMNS];
	logic             col_ovf_q [COLUMNS];

	// Item registers for the accumulate and normalize paths.
	logic [COL_W-1:0]    col_q;
	logic [SAMPLE_W-1:0] smpl_q;
	logic [SAMPLE_W-1:0] mplr_q;
	logic [SQUARE_W-1:0] prod_q;
	logic [SQ_CNT_W-1:0] sq_cnt_q;
	logic                norm_ovf_q;

	// Output register: holds a finished result while the core takes the next item.
	logic                m_valid_q;
	logic [RESULT_W-1:0] m_norm_q;
	logic [COL_W-1:0]    m_col_q;
	logic                m_zero_q;
	logic                m_ovf_q;

	// Control decoded from the state machine.
	logic ctl_ready;
	logic ctl_start;
	logic ctl_add;
	logic ctl_load;
	logic out_free;

	unit_stat_t          unit_stat;
	logic [RESULT_W-1:0] unit_quo;
	logic                unit_zero;

	// The sums have a single read port: the incoming column while idle, the held column otherwise.
	logic [COL_W-1:0] rd_col;
	logic [SUM_W-1:0] rd_sum;
	assign rd_col = (state_q == CORE_IDLE) ? in_col : col_q;
	assign rd_sum = sums_q[rd_col];

	// The serial squarer adds the sample into the upper half when the current multiplier bit is
	// set, then shifts the product right by one; after 16 steps prod_q holds sample * sample.
	logic [SAMPLE_W:0] sq_hi;
	assign sq_hi = {1'b0, prod_q[SQUARE_W-1 -: SAMPLE_W]}
		+ {1'b0, (mplr_q[0] ? smpl_q : {SAMPLE_W{1'b0}})};

	// Saturating sum update; a carry out of 40 bits means the sum passed its maximum.
	logic [SUM_W:0] add_sum;
	logic           add_carry;
	assign add_sum   = {1'b0, rd_sum} + {{(SUM_W+1-SQUARE_W){1'b0}}, prod_q};
	assign add_carry = add_sum[SUM_W];

	assign out_free = !m_valid_q || m_axis_tready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			CORE_IDLE: begin
				if (in_accept) begin
					case (in_mode)
						MODE_ACCUM: state_d = CORE_SQUARE;
						MODE_NORM:  state_d = CORE_NORM;
						default:    state_d = CORE_IDLE;
					endcase
				end
			end
			CORE_SQUARE: begin
				if (sq_cnt_q == SQ_CNT_W'(SQ_STEPS - 1)) begin
					state_d = CORE_ADD;
				end
			end
			CORE_ADD: begin
				state_d = CORE_IDLE;
			end
			CORE_NORM: begin
				if (unit_stat.done) begin
					state_d = CORE_OUT;
				end
			end
			CORE_OUT: begin
				if (out_free) begin
					state_d = CORE_IDLE;
				end
			end
			default: begin
				state_d = CORE_IDLE;
			end
		endcase
	end

	always_comb begin
		ctl_ready = (state_q == CORE_IDLE);
		ctl_start = (state_q == CORE_IDLE) && in_accept && (in_mode == MODE_NORM);
		ctl_add   = (state_q == CORE_ADD);
		ctl_load  = (state_q == CORE_OUT) && out_free;
	end

	assign s_axis_tready = ctl_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CORE_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Column sums and marks: a clear item wipes every column at once, the add step updates one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < COLUMNS; k++) begin
				sums_q[k]    <= '0;
				col_ovf_q[k] <= 1'b0;
			end
		end else if (ctl_ready && in_accept && (in_mode == MODE_CLEAR)) begin
			for (int k = 0; k < COLUMNS; k++) begin
				sums_q[k]    <= '0;
				col_ovf_q[k] <= 1'b0;
			end
		end else if (ctl_add) begin
			if (add_carry) begin
				sums_q[col_q]    <= SUM_MAX;
				col_ovf_q[col_q] <= 1'b1;
			end else begin
				sums_q[col_q] <= add_sum[SUM_W-1:0];
			end
		end
	end

	// Item registers and the serial squarer.
	always_ff @(posedge clk) begin
		if (ctl_ready && in_accept) begin
			col_q      <= in_col;
			smpl_q     <= in_sample;
			mplr_q     <= in_sample;
			prod_q     <= '0;
			sq_cnt_q   <= '0;
			norm_ovf_q <= col_ovf_q[in_col];
		end else if (state_q == CORE_SQUARE) begin
			prod_q   <= {sq_hi, prod_q[SAMPLE_W-1:1]};
			mplr_q   <= {1'b0, mplr_q[SAMPLE_W-1:1]};
			sq_cnt_q <= sq_cnt_q + 1'b1;
		end
	end

	// Root and divide unit. It takes the sum and sample in the cycle the item is accepted.
	cl2n_root_div u_root_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (ctl_start),
		.sum      (rd_sum),
		.sample   (in_sample),
		.stat     (unit_stat),
		.quotient (unit_quo),
		.zero     (unit_zero)
	);

	// Result register with its valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (ctl_load) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl_load) begin
			m_norm_q <= unit_quo;
			m_col_q  <= col_q;
			m_zero_q <= unit_zero;
			m_ovf_q  <= norm_ovf_q;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_norm_q;
	assign m_axis_tuser  = {m_ovf_q, m_zero_q, m_col_q};

	// The unit is only started when it has finished its previous item.
	`CL2N_ASSERT_IMPLY(a_start_when_free, clk, arst_n, ctl_start, !unit_stat.busy)
	// A result is never loaded over one that has not been taken.
	`CL2N_ASSERT_IMPLY(a_no_overwrite, clk, arst_n, ctl_load, !m_valid_q || m_axis_tready)
	// A saturating add leaves its column at the maximum sum with the mark set.
	`CL2N_ASSERT_IMPLY(a_saturate, clk, arst_n, ctl_add && add_carry,
		##1 (sums_q[col_q] == SUM_MAX) && col_ovf_q[col_q])
	// The result stage is entered only after the unit reported completion.
	`CL2N_ASSERT_IMPLY(a_out_after_done, clk, arst_n,
		(state_q == CORE_OUT) && ($past(state_q) == CORE_NORM), $past(unit_stat.done))

endmodule

### verif/tb.sv
// Self-checking testbench for the column L2 normalizer core.
`timescale 1ns / 1ps

module tb;
	import cl2n_pkg::*;

	localparam int          CYCLE_LIMIT  = 1_000_000;
	localparam int          RANDOM_ITEMS = 1400;
	localparam int          TAIL_CYCLES  = 80;
	localparam logic [1:0]  MODE_SPARE   = 2'd3;

	// One predicted result item, in the order the block reports its fields.
	typedef struct packed {
		logic [RESULT_W-1:0] value;
		logic [COL_W-1:0]    column;
		logic                zero;
		logic                ovf;
	} norm_result_t;

	// Keeps its own copy of the column sums and the queue of results they imply.
	class l2_norm_tracker;
		logic [SUM_W-1:0] col_sum [COLUMNS];
		logic             col_sat [COLUMNS];
		norm_result_t     expected_norms [$];
		int               mismatches;

		function new();
			clear_sums();
			mismatches = 0;
		endfunction

		function void clear_sums();
			foreach (col_sum[k]) begin
				col_sum[k] = '0;
				col_sat[k] = 1'b0;
			end
		endfunction

		// Floor square root, settled one root bit at a time from the top.
		function logic [ROOT_W-1:0] floor_sqrt(logic [SUM_W-1:0] v);
			logic [ROOT_W-1:0] root;
			logic [SUM_W-1:0]  trial;
			root = '0;
			for (int i = ROOT_W - 1; i >= 0; i--) begin
				trial = root | (ROOT_W'(1) << i);
				if (trial * trial <= v)
					root = trial[ROOT_W-1:0];
			end
			return root;
		endfunction

		function void take_item(logic [1:0] mode, logic [COL_W-1:0] col,
				logic [SAMPLE_W-1:0] sample);
			logic [SUM_W:0]      grown;
			logic [SUM_W:0]      square;
			logic [ROOT_W-1:0]   root;
			logic [31:0]         dividend;
			logic [31:0]         quot;
			norm_result_t        r;
			case (mode)
				MODE_CLEAR: begin
					clear_sums();
				end
				MODE_ACCUM: begin
					square = sample;
					square = square * square;
					grown = {1'b0, col_sum[col]} + square;
					if (grown > {1'b0, SUM_MAX}) begin
						col_sum[col] = SUM_MAX;
						col_sat[col] = 1'b1;
					end else begin
						col_sum[col] = grown[SUM_W-1:0];
					end
				end
				MODE_NORM: begin
					r.column = col;
					r.ovf = col_sat[col];
					r.zero = 1'b0;
					r.value = '0;
					root = floor_sqrt(col_sum[col]);
					if (col_sum[col] == '0 || root == '0) begin
						r.zero = 1'b1;
					end else begin
						dividend = {sample, 16'h0000};
						quot = dividend / root;
						r.value = (quot > RESULT_MAX) ? RESULT_MAX : quot[RESULT_W-1:0];
					end
					expected_norms.push_back(r);
				end
				default: begin
					// The spare mode leaves the sums alone and answers nothing.
				end
			endcase
		endfunction

		task report_mismatch(string what);
			if (mismatches < 100)
				$display("mismatch at %0t: %s", $realtime, what);
			mismatches++;
		endtask

		task check_result(logic [15:0] data, logic [3:0] user);
			norm_result_t want;
			if (expected_norms.size() == 0) begin
				report_mismatch($sformatf("result with nothing pending, data %h user %h",
					data, user));
				return;
			end
			want = expected_norms.pop_front();
			if (data !== want.value)
				report_mismatch($sformatf("normalized %h, want %h (column %0d)",
					data, want.value, want.column));
			if (user[1:0] !== want.column)
				report_mismatch($sformatf("out_column %h, want %h", user[1:0], want.column));
			if (user[2] !== want.zero)
				report_mismatch($sformatf("zero_norm %b, want %b (column %0d)",
					user[2], want.zero, want.column));
			if (user[3] !== want.ovf)
				report_mismatch($sformatf("sum_overflow %b, want %b (column %0d)",
					user[3], want.ovf, want.column));
		endtask
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata = '0;
	logic [3:0]  s_axis_tuser = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [15:0] m_axis_tdata;
	logic [3:0]  m_axis_tuser;

	l2_norm_tracker tracker;
	int             items_sent = 0;
	int             tx_calm_left = 0;
	int             rx_left = 0;
	int             rx_roll;
	logic           rx_level = 1'b0;
	int             cycles = 0;

	column_l2_normalizer_core u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("tb failed");
			$finish;
		end
	end

	// Result side: check every accepted item, then choose the ready level for
	// the next cycle. Short and long ready stretches mix with short and long stalls.
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			tracker.check_result(m_axis_tdata, m_axis_tuser);
		if (rx_left == 0) begin
			rx_roll = $urandom_range(0, 99);
			if (rx_roll < 60) begin
				rx_level = 1'b1;
				rx_left = $urandom_range(1, 20);
			end else if (rx_roll < 64) begin
				rx_level = 1'b1;
				rx_left = $urandom_range(50, 150);
			end else if (rx_roll < 90) begin
				rx_level = 1'b0;
				rx_left = $urandom_range(1, 3);
			end else if (rx_roll < 98) begin
				rx_level = 1'b0;
				rx_left = $urandom_range(4, 12);
			end else begin
				rx_level = 1'b0;
				rx_left = $urandom_range(20, 60);
			end
		end
		rx_left--;
		m_axis_tready <= rx_level;
	end

	function automatic int pick_gap();
		int roll;
		if (tx_calm_left > 0) begin
			tx_calm_left--;
			return 0;
		end
		roll = $urandom_range(0, 99);
		if (roll < 5) begin
			tx_calm_left = $urandom_range(10, 40);
			return 0;
		end
		if (roll < 55)
			return 0;
		if (roll < 85)
			return $urandom_range(1, 3);
		if (roll < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [15:0] pick_sample();
		int roll;
		roll = $urandom_range(0, 9);
		case (roll)
			0: return 16'h0000;
			1: return 16'hFFFF;
			2, 3: return 16'($urandom_range(1, 255));
			4: return 16'h0001 << $urandom_range(0, 15);
			default: return 16'($urandom_range(0, 16'hFFFF));
		endcase
	endfunction

	// Offer one item, hold it until accepted, then maybe drop valid for a gap.
	// With no gap valid stays high and the next call drives the next item.
	task automatic send_item(input logic [1:0] mode, input logic [1:0] col,
			input logic [15:0] sample);
		int gap;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= sample;
		s_axis_tuser <= {col, mode};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		tracker.take_item(mode, col, sample);
		if (mode != MODE_SPARE)
			items_sent++;
		gap = pick_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (tracker.expected_norms.size() != 0)
			@(posedge clk);
	endtask

	// Fill one column with near full scale squares until its sum saturates, then
	// read it back before and after one more accumulate.
	task automatic saturate_column();
		logic [1:0] col;
		int         n;
		col = 2'($urandom_range(0, COLUMNS - 1));
		n = $urandom_range(260, 280);
		repeat (n)
			send_item(MODE_ACCUM, col, 16'($urandom_range(16'hFF00, 16'hFFFF)));
		repeat ($urandom_range(2, 4))
			send_item(MODE_NORM, col, pick_sample());
		send_item(MODE_ACCUM, col, pick_sample());
		send_item(MODE_NORM, col, pick_sample());
	endtask

	// A well-formed pass: square sums into one column, then normalize against it.
	// A few items go to a random column to mix the sums up.
	task automatic row_pass();
		logic [1:0] col;
		col = 2'($urandom_range(0, COLUMNS - 1));
		repeat ($urandom_range(1, 8)) begin
			if ($urandom_range(0, 99) < 85)
				send_item(MODE_ACCUM, col, pick_sample());
			else
				send_item(MODE_ACCUM, 2'($urandom), pick_sample());
		end
		repeat ($urandom_range(1, 4)) begin
			if ($urandom_range(0, 99) < 90)
				send_item(MODE_NORM, col, pick_sample());
			else
				send_item(MODE_NORM, 2'($urandom), pick_sample());
		end
	endtask

	initial begin
		int  target;
		int  start_count;
		int  roll;
		bit  saturated;
		tracker = new();
		saturated = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: empty columns, tiny and full scale norms, saturating
		// quotients, the spare mode and a clear after use.
		send_item(MODE_CLEAR, 2'd0, 16'h0000);
		send_item(MODE_NORM, 2'd0, 16'h1234);
		send_item(MODE_ACCUM, 2'd1, 16'h0001);
		send_item(MODE_NORM, 2'd1, 16'hFFFF);
		send_item(MODE_NORM, 2'd1, 16'h0000);
		send_item(MODE_NORM, 2'd1, 16'h0001);
		send_item(MODE_ACCUM, 2'd2, 16'hFFFF);
		send_item(MODE_NORM, 2'd2, 16'hFFFF);
		send_item(MODE_ACCUM, 2'd2, 16'h8000);
		send_item(MODE_NORM, 2'd2, 16'h8000);
		send_item(MODE_SPARE, 2'd3, 16'hFFFF);
		send_item(MODE_NORM, 2'd3, 16'hAAAA);
		send_item(MODE_ACCUM, 2'd3, 16'h5555);
		send_item(MODE_NORM, 2'd3, 16'h5555);
		send_item(MODE_ACCUM, 2'd0, 16'h00FF);
		send_item(MODE_NORM, 2'd0, 16'h0100);
		send_item(MODE_CLEAR, 2'd3, 16'hFFFF);
		send_item(MODE_NORM, 2'd2, 16'hFFFF);
		send_item(MODE_NORM, 2'd3, 16'h0000);
		wait_drained();

		start_count = items_sent;
		target = items_sent + RANDOM_ITEMS;
		while (items_sent < target) begin
			roll = $urandom_range(0, 999);
			if (roll < 30) begin
				send_item(MODE_CLEAR, 2'($urandom), 16'($urandom));
			end else if (roll < 50) begin
				send_item(MODE_SPARE, 2'($urandom), 16'($urandom));
			end else if (roll < 54 || (!saturated && items_sent > start_count + 300)) begin
				saturate_column();
				saturated = 1'b1;
			end else if (roll < 70) begin
				wait_drained();
			end else begin
				row_pass();
			end
		end
		s_axis_tvalid <= 1'b0;

		while (tracker.expected_norms.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (tracker.mismatches == 0 && tracker.expected_norms.size() == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

endmodule
